// ----- sv/tpe_pkg.sv -----
// Shared types, constants and entry helpers for the three-level page table engine.
package tpe_pkg;

  localparam int TABLE_PAGES       = 64;
  localparam int ENTRIES_PER_TABLE = 512;
  localparam int STORE_DEPTH       = TABLE_PAGES * ENTRIES_PER_TABLE;
  localparam int PAGE_W            = (TABLE_PAGES > 1) ? $clog2(TABLE_PAGES) : 1;
  localparam int IDX_W             = $clog2(ENTRIES_PER_TABLE);
  localparam int SLOT_W            = PAGE_W + IDX_W;
  localparam int FREE_W            = $clog2(TABLE_PAGES + 1);

  localparam int PPN_W   = 44;
  localparam int FLAG_W  = 10;
  localparam int ENTRY_W = 64;
  localparam int VA_W    = 39;

  localparam logic [PPN_W-1:0] BASE_RESET = 44'd524288;

  localparam logic [1:0] MODE_MAP   = 2'd0;
  localparam logic [1:0] MODE_UNMAP = 2'd1;
  localparam logic [1:0] MODE_WALK  = 2'd2;
  localparam logic [1:0] MODE_CLEAR = 2'd3;

  localparam logic [1:0] SIZE_4K  = 2'd0;
  localparam logic [1:0] SIZE_2M  = 2'd1;
  localparam logic [1:0] SIZE_1G  = 2'd2;
  localparam logic [1:0] SIZE_BAD = 2'd3;

  localparam logic [2:0] ST_OK         = 3'd0;
  localparam logic [2:0] ST_MAPPED     = 3'd1;
  localparam logic [2:0] ST_NOT_MAPPED = 3'd2;
  localparam logic [2:0] ST_BAD_SIZE   = 3'd3;
  localparam logic [2:0] ST_NO_TABLES  = 3'd4;

  typedef struct packed {
    logic [1:0]        mode;
    logic [VA_W-1:0]   virt_addr;
    logic [PPN_W-1:0]  phys_ppn;
    logic [FLAG_W-1:0] pte_flags;
    logic [1:0]        size_code;
  } req_t;

  typedef struct packed {
    logic [2:0]        status;
    logic [PPN_W-1:0]  leaf_ppn;
    logic [FLAG_W-1:0] leaf_flags;
    logic [1:0]        leaf_size;
  } rsp_t;

  typedef struct packed {
    logic              hit;
    logic [PAGE_W-1:0] page;
  } loc_t;

  typedef struct packed {
    logic               en;
    logic [SLOT_W-1:0]  slot;
    logic [ENTRY_W-1:0] data;
  } wr_op_t;

  typedef struct packed {
    logic               we;
    logic [SLOT_W-1:0]  waddr;
    logic [ENTRY_W-1:0] wdata;
    logic [SLOT_W-1:0]  raddr;
    logic               sweep_go;
    logic [SLOT_W-1:0]  sweep_first;
    logic [SLOT_W-1:0]  sweep_last;
  } st_cmd_t;

  function automatic logic is_invalid(input logic [ENTRY_W-1:0] e);
    return !e[0];
  endfunction

  function automatic logic is_pointer(input logic [ENTRY_W-1:0] e);
    return e[3:0] == 4'b0001;
  endfunction

  function automatic logic [PPN_W-1:0] entry_ppn(input logic [ENTRY_W-1:0] e);
    return e[FLAG_W +: PPN_W];
  endfunction

  function automatic logic [ENTRY_W-1:0] make_entry(input logic [PPN_W-1:0] ppn,
                                                    input logic [FLAG_W-1:0] flags);
    return {{(ENTRY_W - PPN_W - FLAG_W){1'b0}}, ppn, flags};
  endfunction

  function automatic logic [ENTRY_W-1:0] pointer_to(input logic [PPN_W-1:0] ppn);
    return make_entry(ppn, FLAG_W'(1));
  endfunction

  function automatic loc_t locate(input logic [PPN_W-1:0] ppn,
                                  input logic [PPN_W-1:0] base);
    logic [PPN_W-1:0] d;
    loc_t             r;
    d      = ppn - base;
    r.hit  = d < PPN_W'(TABLE_PAGES);
    r.page = d[PAGE_W-1:0];
    return r;
  endfunction

  function automatic logic [SLOT_W-1:0] slot_of(input logic [PAGE_W-1:0] page,
                                                input logic [IDX_W-1:0] idx);
    return {page, idx};
  endfunction

endpackage

// ----- sv/tpe_store.sv -----
// Table page store: single-write, registered-read memory with a zeroing sweep engine.
module tpe_store (
  input  logic                              clk,
  input  logic                              rst,
  input  tpe_pkg::st_cmd_t                  cmd,
  output logic [tpe_pkg::ENTRY_W-1:0]       rdata,
  output logic                              busy
);

  logic [tpe_pkg::ENTRY_W-1:0] mem [tpe_pkg::STORE_DEPTH];
  logic [tpe_pkg::SLOT_W-1:0]  sweep_ptr;
  logic [tpe_pkg::SLOT_W-1:0]  sweep_last;
  logic                        wen;
  logic [tpe_pkg::SLOT_W-1:0]  waddr;
  logic [tpe_pkg::ENTRY_W-1:0] wdata;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy       <= 1'b1;
      sweep_ptr  <= '0;
      sweep_last <= tpe_pkg::SLOT_W'(tpe_pkg::STORE_DEPTH - 1);
    end else if (busy) begin
      if (sweep_ptr == sweep_last) begin
        busy <= 1'b0;
      end else begin
        sweep_ptr <= sweep_ptr + 1'b1;
      end
    end else if (cmd.sweep_go) begin
      busy       <= 1'b1;
      sweep_ptr  <= cmd.sweep_first;
      sweep_last <= cmd.sweep_last;
    end
  end

  always_comb begin
    wen   = busy || cmd.we;
    waddr = busy ? sweep_ptr : cmd.waddr;
    wdata = busy ? '0 : cmd.wdata;
  end

  always_ff @(posedge clk) begin
    if (wen) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[cmd.raddr];
  end

  a_no_write_in_sweep: assert property (@(posedge clk) disable iff (rst)
    cmd.we |-> !busy) else $error("table write during sweep");

  a_no_restart: assert property (@(posedge clk) disable iff (rst)
    cmd.sweep_go |-> !busy) else $error("sweep requested while sweeping");

  a_sweep_starts: assert property (@(posedge clk) disable iff (rst)
    cmd.sweep_go |=> busy) else $error("sweep request not taken");

endmodule

// ----- sv/tpe_ctl.sv -----
// Request sequencer: walks the tables, plans allocations and writes, builds the result.
module tpe_ctl (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  tpe_pkg::req_t                     in_data,
  output logic                              res_valid,
  input  logic                              res_ready,
  output tpe_pkg::rsp_t                     res,
  input  logic [tpe_pkg::PPN_W-1:0]         table_base_ppn,
  output tpe_pkg::st_cmd_t                  cmd,
  input  logic [tpe_pkg::ENTRY_W-1:0]       rdata,
  input  logic                              busy
);

  typedef enum logic [11:0] {
    S_IDLE     = 12'b0000_0000_0001,
    S_RD2      = 12'b0000_0000_0010,
    S_EV2      = 12'b0000_0000_0100,
    S_EV1      = 12'b0000_0000_1000,
    S_EV0      = 12'b0000_0001_0000,
    S_WAIT_A   = 12'b0000_0010_0000,
    S_WR_A     = 12'b0000_0100_0000,
    S_WAIT_B   = 12'b0000_1000_0000,
    S_WR_B     = 12'b0001_0000_0000,
    S_WR_C     = 12'b0010_0000_0000,
    S_WAIT_ALL = 12'b0100_0000_0000,
    S_DONE     = 12'b1000_0000_0000
  } state_t;

  state_t                      state, state_next;
  logic [tpe_pkg::FREE_W-1:0]  next_free, next_free_next;
  tpe_pkg::req_t               req, req_next;
  tpe_pkg::loc_t               cur, cur_next;
  tpe_pkg::wr_op_t             wa, wa_next, wb, wb_next, wc, wc_next;
  logic                        alloc_b, alloc_b_next;
  logic                        do_wb, do_wb_next;
  logic                        do_wc, do_wc_next;
  tpe_pkg::rsp_t               res_next;

  logic [tpe_pkg::ENTRY_W-1:0] e;
  tpe_pkg::loc_t               lc;
  logic [tpe_pkg::ENTRY_W-1:0] leaf;
  logic [tpe_pkg::IDX_W-1:0]   v2, v1, v0;
  logic [tpe_pkg::PAGE_W-1:0]  k, k1;
  logic [tpe_pkg::PPN_W-1:0]   ppn_k;
  logic [tpe_pkg::ENTRY_W-1:0] ptr_k, ptr_k1;
  logic                        left1, left2;
  logic                        start_alloc;

  always_comb begin
    e      = cur.hit ? rdata : '0;
    lc     = tpe_pkg::locate(tpe_pkg::entry_ppn(e), table_base_ppn);
    leaf   = tpe_pkg::make_entry(req.phys_ppn, req.pte_flags);
    v2     = req.virt_addr[38:30];
    v1     = req.virt_addr[29:21];
    v0     = req.virt_addr[20:12];
    k      = next_free[tpe_pkg::PAGE_W-1:0];
    k1     = k + 1'b1;
    ppn_k  = table_base_ppn + tpe_pkg::PPN_W'(k);
    ptr_k  = tpe_pkg::pointer_to(ppn_k);
    ptr_k1 = tpe_pkg::pointer_to(ppn_k + tpe_pkg::PPN_W'(1));
    left1  = ({1'b0, next_free} + (tpe_pkg::FREE_W+1)'(1))
             <= (tpe_pkg::FREE_W+1)'(tpe_pkg::TABLE_PAGES);
    left2  = ({1'b0, next_free} + (tpe_pkg::FREE_W+1)'(2))
             <= (tpe_pkg::FREE_W+1)'(tpe_pkg::TABLE_PAGES);
  end

  always_comb begin
    state_next     = state;
    next_free_next = next_free;
    req_next       = req;
    cur_next       = cur;
    wa_next        = wa;
    wb_next        = wb;
    wc_next        = wc;
    alloc_b_next   = alloc_b;
    do_wb_next     = do_wb;
    do_wc_next     = do_wc;
    res_next       = res;
    start_alloc    = 1'b0;
    cmd            = '0;
    in_ready       = 1'b0;
    res_valid      = 1'b0;

    case (state)
      S_IDLE: begin
        in_ready = !busy;
        if (in_valid && !busy) begin
          req_next = in_data;
          res_next = '0;
          if (in_data.mode == tpe_pkg::MODE_CLEAR) begin
            cmd.sweep_go    = 1'b1;
            cmd.sweep_first = '0;
            cmd.sweep_last  = tpe_pkg::SLOT_W'(tpe_pkg::STORE_DEPTH - 1);
            next_free_next  = tpe_pkg::FREE_W'(1);
            state_next      = S_WAIT_ALL;
          end else begin
            state_next = S_RD2;
          end
        end
      end

      S_RD2: begin
        cmd.raddr  = tpe_pkg::slot_of('0, v2);
        cur_next   = '{hit: 1'b1, page: '0};
        state_next = S_EV2;
      end

      S_EV2: begin
        alloc_b_next = 1'b0;
        do_wb_next   = 1'b0;
        do_wc_next   = 1'b0;
        case (req.mode)
          tpe_pkg::MODE_WALK: begin
            if (tpe_pkg::is_pointer(e)) begin
              cmd.raddr  = tpe_pkg::slot_of(lc.page, v1);
              cur_next   = lc;
              state_next = S_EV1;
            end else begin
              res_next.leaf_ppn   = tpe_pkg::entry_ppn(e);
              res_next.leaf_flags = e[tpe_pkg::FLAG_W-1:0];
              res_next.leaf_size  = tpe_pkg::SIZE_1G;
              state_next          = S_DONE;
            end
          end
          tpe_pkg::MODE_UNMAP: begin
            if (tpe_pkg::is_invalid(e)) begin
              res_next.status = tpe_pkg::ST_NOT_MAPPED;
              state_next      = S_DONE;
            end else if (!tpe_pkg::is_pointer(e)) begin
              wa_next    = '{en: 1'b1, slot: tpe_pkg::slot_of('0, v2), data: '0};
              state_next = S_WR_A;
            end else begin
              cmd.raddr  = tpe_pkg::slot_of(lc.page, v1);
              cur_next   = lc;
              state_next = S_EV1;
            end
          end
          tpe_pkg::MODE_MAP: begin
            if (req.size_code == tpe_pkg::SIZE_BAD) begin
              res_next.status = tpe_pkg::ST_BAD_SIZE;
              state_next      = S_DONE;
            end else if (req.size_code == tpe_pkg::SIZE_1G) begin
              if (!tpe_pkg::is_invalid(e)) begin
                res_next.status = tpe_pkg::ST_MAPPED;
                state_next      = S_DONE;
              end else begin
                wa_next    = '{en: 1'b1, slot: tpe_pkg::slot_of('0, v2), data: leaf};
                state_next = S_WR_A;
              end
            end else if (tpe_pkg::is_pointer(e)) begin
              cmd.raddr  = tpe_pkg::slot_of(lc.page, v1);
              cur_next   = lc;
              state_next = S_EV1;
            end else if (!tpe_pkg::is_invalid(e)) begin
              res_next.status = tpe_pkg::ST_MAPPED;
              state_next      = S_DONE;
            end else if (!((req.size_code == tpe_pkg::SIZE_2M) ? left1 : left2)) begin
              res_next.status = tpe_pkg::ST_NO_TABLES;
              state_next      = S_DONE;
            end else begin
              start_alloc = 1'b1;
              wa_next     = '{en: 1'b1, slot: tpe_pkg::slot_of('0, v2), data: ptr_k};
              do_wb_next  = 1'b1;
              if (req.size_code == tpe_pkg::SIZE_2M) begin
                wb_next = '{en: 1'b1, slot: tpe_pkg::slot_of(k, v1), data: leaf};
              end else begin
                alloc_b_next = 1'b1;
                do_wc_next   = 1'b1;
                wb_next = '{en: 1'b1, slot: tpe_pkg::slot_of(k, v1), data: ptr_k1};
                wc_next = '{en: 1'b1, slot: tpe_pkg::slot_of(k1, v0), data: leaf};
              end
              state_next = S_WAIT_A;
            end
          end
          default: begin
            state_next = S_DONE;
          end
        endcase
      end

      S_EV1: begin
        case (req.mode)
          tpe_pkg::MODE_WALK: begin
            if (tpe_pkg::is_pointer(e)) begin
              cmd.raddr  = tpe_pkg::slot_of(lc.page, v0);
              cur_next   = lc;
              state_next = S_EV0;
            end else begin
              res_next.leaf_ppn   = tpe_pkg::entry_ppn(e);
              res_next.leaf_flags = e[tpe_pkg::FLAG_W-1:0];
              res_next.leaf_size  = tpe_pkg::SIZE_2M;
              state_next          = S_DONE;
            end
          end
          tpe_pkg::MODE_UNMAP: begin
            if (tpe_pkg::is_invalid(e)) begin
              res_next.status = tpe_pkg::ST_NOT_MAPPED;
              state_next      = S_DONE;
            end else if (!tpe_pkg::is_pointer(e)) begin
              wa_next    = '{en: cur.hit, slot: tpe_pkg::slot_of(cur.page, v1), data: '0};
              state_next = S_WR_A;
            end else begin
              cmd.raddr  = tpe_pkg::slot_of(lc.page, v0);
              cur_next   = lc;
              state_next = S_EV0;
            end
          end
          tpe_pkg::MODE_MAP: begin
            if (req.size_code == tpe_pkg::SIZE_2M) begin
              if (!tpe_pkg::is_invalid(e)) begin
                res_next.status = tpe_pkg::ST_MAPPED;
                state_next      = S_DONE;
              end else begin
                wa_next    = '{en: cur.hit, slot: tpe_pkg::slot_of(cur.page, v1),
                               data: leaf};
                state_next = S_WR_A;
              end
            end else if (tpe_pkg::is_pointer(e)) begin
              cmd.raddr  = tpe_pkg::slot_of(lc.page, v0);
              cur_next   = lc;
              state_next = S_EV0;
            end else if (!tpe_pkg::is_invalid(e)) begin
              res_next.status = tpe_pkg::ST_MAPPED;
              state_next      = S_DONE;
            end else if (!left1) begin
              res_next.status = tpe_pkg::ST_NO_TABLES;
              state_next      = S_DONE;
            end else begin
              start_alloc = 1'b1;
              wa_next     = '{en: 1'b1, slot: tpe_pkg::slot_of(k, v0), data: leaf};
              do_wb_next  = 1'b1;
              wb_next     = '{en: cur.hit, slot: tpe_pkg::slot_of(cur.page, v1),
                              data: ptr_k};
              state_next  = S_WAIT_A;
            end
          end
          default: begin
            state_next = S_DONE;
          end
        endcase
      end

      S_EV0: begin
        case (req.mode)
          tpe_pkg::MODE_WALK: begin
            res_next.leaf_ppn   = tpe_pkg::entry_ppn(e);
            res_next.leaf_flags = e[tpe_pkg::FLAG_W-1:0];
            res_next.leaf_size  = tpe_pkg::SIZE_4K;
            state_next          = S_DONE;
          end
          tpe_pkg::MODE_UNMAP: begin
            if (tpe_pkg::is_invalid(e)) begin
              res_next.status = tpe_pkg::ST_NOT_MAPPED;
              state_next      = S_DONE;
            end else begin
              wa_next    = '{en: cur.hit, slot: tpe_pkg::slot_of(cur.page, v0), data: '0};
              state_next = S_WR_A;
            end
          end
          tpe_pkg::MODE_MAP: begin
            if (!tpe_pkg::is_invalid(e)) begin
              res_next.status = tpe_pkg::ST_MAPPED;
              state_next      = S_DONE;
            end else begin
              wa_next    = '{en: cur.hit, slot: tpe_pkg::slot_of(cur.page, v0), data: leaf};
              state_next = S_WR_A;
            end
          end
          default: begin
            state_next = S_DONE;
          end
        endcase
      end

      S_WAIT_A: begin
        if (!busy) begin
          state_next = S_WR_A;
        end
      end

      S_WR_A: begin
        cmd.we    = wa.en;
        cmd.waddr = wa.slot;
        cmd.wdata = wa.data;
        if (alloc_b) begin
          start_alloc = 1'b1;
          state_next  = S_WAIT_B;
        end else if (do_wb) begin
          state_next = S_WR_B;
        end else begin
          state_next = S_DONE;
        end
      end

      S_WAIT_B: begin
        if (!busy) begin
          state_next = S_WR_B;
        end
      end

      S_WR_B: begin
        cmd.we     = wb.en;
        cmd.waddr  = wb.slot;
        cmd.wdata  = wb.data;
        state_next = do_wc ? S_WR_C : S_DONE;
      end

      S_WR_C: begin
        cmd.we     = wc.en;
        cmd.waddr  = wc.slot;
        cmd.wdata  = wc.data;
        state_next = S_DONE;
      end

      S_WAIT_ALL: begin
        if (!busy) begin
          state_next = S_DONE;
        end
      end

      S_DONE: begin
        res_valid = 1'b1;
        if (res_ready) begin
          state_next = S_IDLE;
        end
      end

      default: begin
        state_next = S_IDLE;
      end
    endcase

    if (start_alloc) begin
      cmd.sweep_go    = 1'b1;
      cmd.sweep_first = tpe_pkg::slot_of(k, '0);
      cmd.sweep_last  = tpe_pkg::slot_of(k, '1);
      next_free_next  = next_free + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      next_free <= tpe_pkg::FREE_W'(1);
    end else begin
      state     <= state_next;
      next_free <= next_free_next;
    end
  end

  always_ff @(posedge clk) begin
    req     <= req_next;
    cur     <= cur_next;
    wa      <= wa_next;
    wb      <= wb_next;
    wc      <= wc_next;
    alloc_b <= alloc_b_next;
    do_wb   <= do_wb_next;
    do_wc   <= do_wc_next;
    res     <= res_next;
  end

  a_free_range: assert property (@(posedge clk) disable iff (rst)
    (next_free >= tpe_pkg::FREE_W'(1)) &&
    (next_free <= tpe_pkg::FREE_W'(tpe_pkg::TABLE_PAGES)))
    else $error("table allocator out of range");

  a_write_after_sweep: assert property (@(posedge clk) disable iff (rst)
    (state == S_WR_A || state == S_WR_B || state == S_WR_C) |-> !busy)
    else $error("table write while page still clearing");

  a_wr_b_order: assert property (@(posedge clk) disable iff (rst)
    (state == S_WR_B) |-> ($past(state) == S_WR_A || $past(state) == S_WAIT_B))
    else $error("second write out of sequence");

endmodule

// ----- sv/three_level_page_table_engine.sv -----
// Three-level page table engine top level: config register, sequencer, store, result register.
//
// Sv39-layout page tables (512 entries a table, TABLE_PAGES pages) live in one
// synchronous memory with a registered read. Each request is taken alone: walk
// reads the root entry and follows pointers one level at a time; unmap does the
// same and then clears the leaf it finds; map follows pointers the same way, then
// writes its leaf and any new pointers, and each newly allocated table page is
// first zeroed one entry a cycle through the single write port. Clear and reset
// zero the whole store (TABLE_PAGES * ENTRIES_PER_TABLE entries, 32768 as built);
// no request is accepted until that sweep ends, while configuration writes
// are taken at any time. A finished result waits in an output register, so the
// next request can be accepted before the last result is taken.
module three_level_page_table_engine (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       in_valid,
  output logic                       in_ready,
  input  tpe_pkg::req_t              in_data,
  output logic                       out_valid,
  input  logic                       out_ready,
  output tpe_pkg::rsp_t              out_data,
  input  logic                       cfg_we,
  input  logic [tpe_pkg::PPN_W-1:0]  cfg_wdata
);

  logic [tpe_pkg::PPN_W-1:0]   table_base_ppn;
  logic                        res_valid;
  logic                        res_ready;
  tpe_pkg::rsp_t               res;
  tpe_pkg::st_cmd_t            cmd;
  logic [tpe_pkg::ENTRY_W-1:0] rdata;
  logic                        busy;

  always_ff @(posedge clk) begin
    if (rst) begin
      table_base_ppn <= tpe_pkg::BASE_RESET;
    end else if (cfg_we) begin
      table_base_ppn <= cfg_wdata;
    end
  end

  assign res_ready = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (res_valid && res_ready) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_valid && res_ready) begin
      out_data <= res;
    end
  end

  tpe_ctl u_ctl (
    .clk            (clk),
    .rst            (rst),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_data        (in_data),
    .res_valid      (res_valid),
    .res_ready      (res_ready),
    .res            (res),
    .table_base_ppn (table_base_ppn),
    .cmd            (cmd),
    .rdata          (rdata),
    .busy           (busy)
  );

  tpe_store u_store (
    .clk   (clk),
    .rst   (rst),
    .cmd   (cmd),
    .rdata (rdata),
    .busy  (busy)
  );

endmodule

// ----- tb/tb_three_level_page_table_engine.sv -----
`timescale 1ns / 100ps
// Self-checking testbench for the three-level page table engine with its own page table mirror.
module tb_three_level_page_table_engine;

  localparam int unsigned RUN_LIMIT = 2_000_000;
  localparam int RX_HOLD = 300;
  localparam int MAX_SHOWN = 10;

  logic clk;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_ready;
  tpe_pkg::req_t in_data = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  tpe_pkg::rsp_t out_data;
  logic cfg_we = 1'b0;
  logic [tpe_pkg::PPN_W-1:0] cfg_wdata = '0;

  three_level_page_table_engine i_dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata)
  );

  bit [tpe_pkg::ENTRY_W-1:0] tbl_mem [tpe_pkg::STORE_DEPTH];
  int unsigned free_pg = 1;
  bit [tpe_pkg::PPN_W-1:0] tbl_base = tpe_pkg::BASE_RESET;

  tpe_pkg::req_t pending_reqs[$];
  tpe_pkg::rsp_t due_rsps[$];
  int errs = 0;
  int unsigned cycles = 0;
  bit tx_idle_en = 1'b1;
  bit rx_idle_en = 1'b1;
  int tx_gap = 0;
  int rx_stall = 0;
  int hold_left = 0;
  int holds_asked = 0;
  int holds_done = 0;

  bit [8:0] pool2 [6] = '{9'd0, 9'd511, 9'd5, 9'd77, 9'd300, 9'd128};
  bit [8:0] pool1 [6] = '{9'd0, 9'd511, 9'd1, 9'd42, 9'd256, 9'd9};
  bit [8:0] pool0 [6] = '{9'd0, 9'd511, 9'd3, 9'd64, 9'd200, 9'd17};

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  initial begin
    repeat (12) @(posedge clk);
    rst <= 1'b0;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == RUN_LIMIT) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  function automatic bit pte_live(input bit [tpe_pkg::ENTRY_W-1:0] e);
    return e[0];
  endfunction

  function automatic bit pte_link(input bit [tpe_pkg::ENTRY_W-1:0] e);
    return e[3:0] == 4'b0001;
  endfunction

  function automatic bit [tpe_pkg::PPN_W-1:0] pte_next(input bit [tpe_pkg::ENTRY_W-1:0] e);
    return e[tpe_pkg::FLAG_W +: tpe_pkg::PPN_W];
  endfunction

  function automatic bit [tpe_pkg::ENTRY_W-1:0] link_to(input bit [tpe_pkg::PPN_W-1:0] ppn);
    return {10'b0, ppn, 10'h001};
  endfunction

  function automatic bit store_slot(input bit [tpe_pkg::PPN_W-1:0] ppn,
                                    input bit [tpe_pkg::IDX_W-1:0] idx,
                                    output bit [tpe_pkg::SLOT_W-1:0] slot);
    bit [tpe_pkg::PPN_W-1:0] d;
    d = ppn - tbl_base;
    slot = '0;
    if (d >= tpe_pkg::PPN_W'(tpe_pkg::TABLE_PAGES)) return 1'b0;
    slot = {d[tpe_pkg::PAGE_W-1:0], idx};
    return 1'b1;
  endfunction

  function automatic bit [tpe_pkg::ENTRY_W-1:0] read_pte(input bit [tpe_pkg::PPN_W-1:0] ppn,
                                                         input bit [tpe_pkg::IDX_W-1:0] idx);
    bit [tpe_pkg::SLOT_W-1:0] s;
    if (store_slot(ppn, idx, s)) return tbl_mem[s];
    return '0;
  endfunction

  function automatic void write_pte(input bit [tpe_pkg::PPN_W-1:0] ppn,
                                    input bit [tpe_pkg::IDX_W-1:0] idx,
                                    input bit [tpe_pkg::ENTRY_W-1:0] v);
    bit [tpe_pkg::SLOT_W-1:0] s;
    if (store_slot(ppn, idx, s)) tbl_mem[s] = v;
  endfunction

  function automatic bit [tpe_pkg::PPN_W-1:0] take_table();
    int unsigned k;
    k = free_pg;
    free_pg++;
    for (int i = 0; i < tpe_pkg::ENTRIES_PER_TABLE; i++)
      tbl_mem[{k[tpe_pkg::PAGE_W-1:0], tpe_pkg::IDX_W'(i)}] = '0;
    return tbl_base + tpe_pkg::PPN_W'(k);
  endfunction

  function automatic bit [2:0] map_page(input bit [tpe_pkg::IDX_W-1:0] i2, i1, i0,
                                        input bit [tpe_pkg::ENTRY_W-1:0] leaf,
                                        input bit [1:0] sz);
    bit [tpe_pkg::ENTRY_W-1:0] e2;
    bit [tpe_pkg::ENTRY_W-1:0] e1;
    bit [tpe_pkg::PPN_W-1:0] t1;
    bit [tpe_pkg::PPN_W-1:0] t0;
    if (sz == tpe_pkg::SIZE_BAD) return tpe_pkg::ST_BAD_SIZE;
    e2 = read_pte(tbl_base, i2);
    if (sz == tpe_pkg::SIZE_1G) begin
      if (pte_live(e2)) return tpe_pkg::ST_MAPPED;
      write_pte(tbl_base, i2, leaf);
      return tpe_pkg::ST_OK;
    end
    if (pte_link(e2)) begin
      t1 = pte_next(e2);
      e1 = read_pte(t1, i1);
      if (sz == tpe_pkg::SIZE_2M) begin
        if (pte_live(e1)) return tpe_pkg::ST_MAPPED;
        write_pte(t1, i1, leaf);
        return tpe_pkg::ST_OK;
      end
      if (pte_link(e1)) begin
        t0 = pte_next(e1);
        if (pte_live(read_pte(t0, i0))) return tpe_pkg::ST_MAPPED;
        write_pte(t0, i0, leaf);
        return tpe_pkg::ST_OK;
      end
      if (pte_live(e1)) return tpe_pkg::ST_MAPPED;
      if (free_pg + 1 > tpe_pkg::TABLE_PAGES) return tpe_pkg::ST_NO_TABLES;
      t0 = take_table();
      write_pte(t0, i0, leaf);
      write_pte(t1, i1, link_to(t0));
      return tpe_pkg::ST_OK;
    end
    if (pte_live(e2)) return tpe_pkg::ST_MAPPED;
    if (free_pg + ((sz == tpe_pkg::SIZE_2M) ? 1 : 2) > tpe_pkg::TABLE_PAGES)
      return tpe_pkg::ST_NO_TABLES;
    t1 = take_table();
    write_pte(tbl_base, i2, link_to(t1));
    if (sz == tpe_pkg::SIZE_2M) begin
      write_pte(t1, i1, leaf);
      return tpe_pkg::ST_OK;
    end
    t0 = take_table();
    write_pte(t1, i1, link_to(t0));
    write_pte(t0, i0, leaf);
    return tpe_pkg::ST_OK;
  endfunction

  function automatic bit [2:0] unmap_page(input bit [tpe_pkg::IDX_W-1:0] i2, i1, i0);
    bit [tpe_pkg::ENTRY_W-1:0] e2;
    bit [tpe_pkg::ENTRY_W-1:0] e1;
    bit [tpe_pkg::PPN_W-1:0] t1;
    bit [tpe_pkg::PPN_W-1:0] t0;
    e2 = read_pte(tbl_base, i2);
    if (!pte_live(e2)) return tpe_pkg::ST_NOT_MAPPED;
    if (!pte_link(e2)) begin
      write_pte(tbl_base, i2, '0);
      return tpe_pkg::ST_OK;
    end
    t1 = pte_next(e2);
    e1 = read_pte(t1, i1);
    if (!pte_live(e1)) return tpe_pkg::ST_NOT_MAPPED;
    if (!pte_link(e1)) begin
      write_pte(t1, i1, '0);
      return tpe_pkg::ST_OK;
    end
    t0 = pte_next(e1);
    if (!pte_live(read_pte(t0, i0))) return tpe_pkg::ST_NOT_MAPPED;
    write_pte(t0, i0, '0);
    return tpe_pkg::ST_OK;
  endfunction

  function automatic tpe_pkg::rsp_t engine_result(input tpe_pkg::req_t r);
    tpe_pkg::rsp_t o;
    bit [tpe_pkg::ENTRY_W-1:0] e;
    bit [tpe_pkg::IDX_W-1:0] i2;
    bit [tpe_pkg::IDX_W-1:0] i1;
    bit [tpe_pkg::IDX_W-1:0] i0;
    o = '0;
    i2 = r.virt_addr[38:30];
    i1 = r.virt_addr[29:21];
    i0 = r.virt_addr[20:12];
    case (r.mode)
      tpe_pkg::MODE_MAP: begin
        o.status = map_page(i2, i1, i0, {10'b0, r.phys_ppn, r.pte_flags}, r.size_code);
      end
      tpe_pkg::MODE_UNMAP: begin
        o.status = unmap_page(i2, i1, i0);
      end
      tpe_pkg::MODE_WALK: begin
        e = read_pte(tbl_base, i2);
        o.leaf_size = tpe_pkg::SIZE_1G;
        if (pte_link(e)) begin
          e = read_pte(pte_next(e), i1);
          o.leaf_size = tpe_pkg::SIZE_2M;
          if (pte_link(e)) begin
            e = read_pte(pte_next(e), i0);
            o.leaf_size = tpe_pkg::SIZE_4K;
          end
        end
        o.leaf_ppn = pte_next(e);
        o.leaf_flags = e[tpe_pkg::FLAG_W-1:0];
      end
      default: begin
        foreach (tbl_mem[i]) tbl_mem[i] = '0;
        free_pg = 1;
      end
    endcase
    return o;
  endfunction

  task automatic check_rsp(input tpe_pkg::rsp_t got);
    tpe_pkg::rsp_t want;
    if (due_rsps.size() == 0) begin
      errs++;
      if (errs <= MAX_SHOWN)
        $display("%0t: result beat with no request pending: status %0d ppn %h flags %h size %0d",
                 $time, got.status, got.leaf_ppn, got.leaf_flags, got.leaf_size);
      return;
    end
    want = due_rsps.pop_front();
    if (got.status !== want.status || got.leaf_ppn !== want.leaf_ppn ||
        got.leaf_flags !== want.leaf_flags || got.leaf_size !== want.leaf_size) begin
      errs++;
      if (errs <= MAX_SHOWN)
        $display("%0t: mismatch exp/act status %0d/%0d ppn %h/%h flags %h/%h size %0d/%0d",
                 $time, want.status, got.status, want.leaf_ppn, got.leaf_ppn,
                 want.leaf_flags, got.leaf_flags, want.leaf_size, got.leaf_size);
    end
  endtask

  always @(posedge clk) begin : p_drive
    logic nv;
    tpe_pkg::req_t nd;
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      nv = in_valid;
      nd = in_data;
      if (in_valid && in_ready) begin
        due_rsps.push_back(engine_result(in_data));
        nv = 1'b0;
      end
      if (!nv) begin
        if (tx_gap > 0) begin
          tx_gap--;
        end else if (tx_idle_en && $urandom_range(0, 7) == 0) begin
          tx_gap = $urandom_range(0, 4);
        end else if (pending_reqs.size() > 0) begin
          nv = 1'b1;
          nd = pending_reqs.pop_front();
        end
      end
      in_valid <= nv;
      in_data <= nd;
    end
  end

  always @(posedge clk) begin : p_sink
    if (rst) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) check_rsp(out_data);
      if (holds_done < holds_asked) begin
        holds_done++;
        hold_left = RX_HOLD;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ready <= 1'b0;
      end else if (rx_stall > 0) begin
        rx_stall--;
        out_ready <= 1'b0;
      end else if (rx_idle_en && $urandom_range(0, 7) == 0) begin
        rx_stall = $urandom_range(0, 4);
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  function automatic tpe_pkg::req_t make_req(input logic [1:0] m,
                                             input bit [tpe_pkg::VA_W-1:0] va,
                                             input bit [tpe_pkg::PPN_W-1:0] ppn,
                                             input bit [tpe_pkg::FLAG_W-1:0] fl,
                                             input logic [1:0] sz);
    tpe_pkg::req_t r;
    r.mode = m;
    r.virt_addr = va;
    r.phys_ppn = ppn;
    r.pte_flags = fl;
    r.size_code = sz;
    return r;
  endfunction

  function automatic bit [tpe_pkg::VA_W-1:0] va_of(input bit [8:0] i2, i1, i0,
                                                   input bit [11:0] off);
    return {i2, i1, i0, off};
  endfunction

  function automatic bit [tpe_pkg::VA_W-1:0] rand_va();
    if ($urandom_range(0, 9) < 3) return tpe_pkg::VA_W'({$urandom, $urandom});
    return va_of(pool2[$urandom_range(0, 5)], pool1[$urandom_range(0, 5)],
                 pool0[$urandom_range(0, 5)], 12'($urandom));
  endfunction

  function automatic bit [tpe_pkg::PPN_W-1:0] rand_ppn();
    case ($urandom_range(0, 9))
      0: return '1;
      1: return '0;
      2, 3: return tbl_base + tpe_pkg::PPN_W'($urandom_range(0, tpe_pkg::TABLE_PAGES + 4));
      default: return tpe_pkg::PPN_W'({$urandom, $urandom});
    endcase
  endfunction

  function automatic bit [tpe_pkg::FLAG_W-1:0] rand_flags();
    int r;
    r = $urandom_range(0, 19);
    if (r < 13) return {6'($urandom), 3'($urandom_range(1, 7)), 1'b1};
    if (r < 16) return tpe_pkg::FLAG_W'($urandom);
    if (r < 18) return 10'h001;
    return {9'($urandom), 1'b0};
  endfunction

  function automatic logic [1:0] rand_size();
    int r;
    r = $urandom_range(0, 19);
    if (r < 8) return tpe_pkg::SIZE_4K;
    if (r < 13) return tpe_pkg::SIZE_2M;
    if (r < 18) return tpe_pkg::SIZE_1G;
    return tpe_pkg::SIZE_BAD;
  endfunction

  task automatic push_op(input logic [1:0] m, input bit [tpe_pkg::VA_W-1:0] va);
    pending_reqs.push_back(make_req(m, va, rand_ppn(), rand_flags(), rand_size()));
  endtask

  task automatic push_random(input int n);
    int cnt;
    int r;
    bit [tpe_pkg::VA_W-1:0] va;
    cnt = 0;
    while (cnt < n) begin
      r = $urandom_range(0, 9);
      va = rand_va();
      if (r < 6) begin
        push_op(tpe_pkg::MODE_MAP, va);
        push_op(tpe_pkg::MODE_WALK, va);
        cnt += 2;
        if ($urandom_range(0, 1) == 1) begin
          push_op(tpe_pkg::MODE_UNMAP, va);
          push_op(tpe_pkg::MODE_WALK, va);
          cnt += 2;
        end
      end else if (r < 8) begin
        push_op(tpe_pkg::MODE_WALK, va);
        cnt++;
      end else if (r < 9) begin
        push_op(tpe_pkg::MODE_UNMAP, va);
        cnt++;
      end else begin
        push_op(tpe_pkg::MODE_MAP, va);
        cnt++;
      end
    end
  endtask

  task automatic wait_idle();
    do @(negedge clk);
    while (pending_reqs.size() != 0 || in_valid || due_rsps.size() != 0);
  endtask

  task automatic write_base(input bit [tpe_pkg::PPN_W-1:0] v);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_wdata <= v;
    tbl_base = v;
    @(posedge clk);
    cfg_we <= 1'b0;
    @(negedge clk);
  endtask

  initial begin : p_stim
    do @(negedge clk);
    while (rst);

    pending_reqs.push_back(make_req(tpe_pkg::MODE_WALK, '0, '0, '0, tpe_pkg::SIZE_4K));
    pending_reqs.push_back(make_req(tpe_pkg::MODE_MAP, va_of(9'd0, 9'd0, 9'd0, 12'd0),
                                    '1, 10'h3FF, tpe_pkg::SIZE_4K));
    pending_reqs.push_back(make_req(tpe_pkg::MODE_WALK, va_of(9'd0, 9'd0, 9'd0, 12'hFFF),
                                    '0, '0, tpe_pkg::SIZE_4K));
    pending_reqs.push_back(make_req(tpe_pkg::MODE_MAP, va_of(9'd0, 9'd0, 9'd0, 12'd0),
                                    44'd5, 10'h00B, tpe_pkg::SIZE_4K));
    pending_reqs.push_back(make_req(tpe_pkg::MODE_MAP, va_of(9'd3, 9'd3, 9'd3, 12'd0),
                                    44'd7, 10'h00F, tpe_pkg::SIZE_BAD));
    pending_reqs.push_back(make_req(tpe_pkg::MODE_MAP, va_of(9'd0, 9'd0, 9'd5, 12'd0),
                                    44'd9, 10'h003, tpe_pkg::SIZE_2M));
    pending_reqs.push_back(make_req(tpe_pkg::MODE_MAP, va_of(9'd511, 9'd511, 9'd0, 12'd0),
                                    '0, 10'h00F, tpe_pkg::SIZE_2M));
    pending_reqs.push_back(make_req(tpe_pkg::MODE_MAP, va_of(9'd511, 9'd511, 9'd7, 12'd0),
                                    44'd1, 10'h007, tpe_pkg::SIZE_4K));
    pending_reqs.push_back(make_req(tpe_pkg::MODE_MAP, va_of(9'd1, 9'd0, 9'd0, 12'd0),
                                    44'h123456789AB, 10'h0CF, tpe_pkg::SIZE_1G));
    pending_reqs.push_back(make_req(tpe_pkg::MODE_MAP, va_of(9'd1, 9'd2, 9'd3, 12'd0),
                                    44'd2, 10'h003, tpe_pkg::SIZE_4K));
    pending_reqs.push_back(make_req(tpe_pkg::MODE_WALK, va_of(9'd511, 9'd511, 9'd0, 12'd0),
                                    '0, '0, tpe_pkg::SIZE_4K));
    pending_reqs.push_back(make_req(tpe_pkg::MODE_UNMAP, va_of(9'd1, 9'd0, 9'd0, 12'd0),
                                    '0, '0, tpe_pkg::SIZE_4K));
    pending_reqs.push_back(make_req(tpe_pkg::MODE_UNMAP, va_of(9'd1, 9'd0, 9'd0, 12'd0),
                                    '0, '0, tpe_pkg::SIZE_4K));
    pending_reqs.push_back(make_req(tpe_pkg::MODE_UNMAP, va_of(9'd511, 9'd511, 9'd0, 12'd0),
                                    '0, '0, tpe_pkg::SIZE_4K));
    pending_reqs.push_back(make_req(tpe_pkg::MODE_UNMAP, va_of(9'd0, 9'd0, 9'd0, 12'd0),
                                    '0, '0, tpe_pkg::SIZE_4K));
    pending_reqs.push_back(make_req(tpe_pkg::MODE_UNMAP, va_of(9'd0, 9'd0, 9'd0, 12'd0),
                                    '0, '0, tpe_pkg::SIZE_4K));
    pending_reqs.push_back(make_req(tpe_pkg::MODE_WALK, va_of(9'd0, 9'd0, 9'd0, 12'd0),
                                    '0, '0, tpe_pkg::SIZE_4K));
    pending_reqs.push_back(make_req(tpe_pkg::MODE_MAP, va_of(9'd0, 9'd0, 9'd9, 12'd0),
                                    44'd11, 10'h3FE, tpe_pkg::SIZE_4K));
    pending_reqs.push_back(make_req(tpe_pkg::MODE_MAP, va_of(9'd0, 9'd0, 9'd9, 12'd0),
                                    44'd12, 10'h3FF, tpe_pkg::SIZE_4K));
    pending_reqs.push_back(make_req(tpe_pkg::MODE_MAP, va_of(9'd2, 9'd0, 9'd0, 12'd0),
                                    tbl_base + 44'd63, 10'h001, tpe_pkg::SIZE_1G));
    pending_reqs.push_back(make_req(tpe_pkg::MODE_MAP, va_of(9'd2, 9'd4, 9'd0, 12'd0),
                                    44'd13, 10'h00F, tpe_pkg::SIZE_2M));
    pending_reqs.push_back(make_req(tpe_pkg::MODE_MAP, va_of(9'd3, 9'd0, 9'd0, 12'd0),
                                    '0, 10'h001, tpe_pkg::SIZE_1G));
    pending_reqs.push_back(make_req(tpe_pkg::MODE_MAP, va_of(9'd3, 9'd1, 9'd0, 12'd0),
                                    44'd14, 10'h00F, tpe_pkg::SIZE_2M));
    pending_reqs.push_back(make_req(tpe_pkg::MODE_WALK, va_of(9'd3, 9'd1, 9'd0, 12'd0),
                                    '0, '0, tpe_pkg::SIZE_4K));
    pending_reqs.push_back(make_req(tpe_pkg::MODE_WALK, '1, '1, '1, tpe_pkg::SIZE_BAD));
    pending_reqs.push_back(make_req(tpe_pkg::MODE_CLEAR, '1, '1, '1, tpe_pkg::SIZE_BAD));
    pending_reqs.push_back(make_req(tpe_pkg::MODE_WALK, va_of(9'd0, 9'd0, 9'd0, 12'd0),
                                    '0, '0, tpe_pkg::SIZE_4K));
    wait_idle();

    write_base(tpe_pkg::BASE_RESET + 44'd3);
    for (int i = 0; i < 34; i++)
      pending_reqs.push_back(make_req(tpe_pkg::MODE_MAP, va_of(9'(i * 15 + 2), 9'($urandom),
                                      9'($urandom), 12'($urandom)), rand_ppn(),
                                      {6'($urandom), 3'($urandom_range(1, 7)), 1'b1},
                                      tpe_pkg::SIZE_4K));
    push_random(60);
    holds_asked++;
    wait_idle();
    push_op(tpe_pkg::MODE_CLEAR, rand_va());
    push_random(60);
    wait_idle();

    tx_idle_en = 1'b0;
    write_base('0);
    push_random(60);
    push_op(tpe_pkg::MODE_CLEAR, rand_va());
    push_random(60);
    wait_idle();

    tx_idle_en = 1'b1;
    write_base('1);
    push_random(50);
    holds_asked++;
    push_random(50);
    wait_idle();

    tx_idle_en = 1'b0;
    rx_idle_en = 1'b0;
    write_base(tpe_pkg::PPN_W'({$urandom, $urandom}));
    push_random(40);
    wait_idle();

    repeat (20) @(posedge clk);
    if (errs == 0 && due_rsps.size() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
